// ===== rtl/adpa_pkg.sv =====
// Shared opcodes, shifter codes and stage word types for the data-processing ALU.
package adpa_pkg;

    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'ha;
    localparam logic [3:0] OP_CMN = 4'hb;
    localparam logic [3:0] OP_ORR = 4'hc;
    localparam logic [3:0] OP_MOV = 4'hd;
    localparam logic [3:0] OP_BIC = 4'he;
    localparam logic [3:0] OP_MVN = 4'hf;

    localparam logic [1:0] ST_LSL = 2'd0;
    localparam logic [1:0] ST_LSR = 2'd1;
    localparam logic [1:0] ST_ASR = 2'd2;
    localparam logic [1:0] ST_ROR = 2'd3;

    localparam logic [2:0] SK_PASS = 3'd0;
    localparam logic [2:0] SK_LSL  = 3'd1;
    localparam logic [2:0] SK_LSR  = 3'd2;
    localparam logic [2:0] SK_ASR  = 3'd3;
    localparam logic [2:0] SK_ROR  = 3'd4;
    localparam logic [2:0] SK_RRX  = 3'd5;
    localparam logic [2:0] SK_ZERO = 3'd6;
    localparam logic [2:0] SK_SIGN = 3'd7;

    localparam logic [3:0] RD_PC = 4'hf;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  amount;
        logic [2:0]  kind;
        logic        fixed_carry;
        logic [3:0]  opcode;
        logic        set;
        logic [3:0]  rd;
        logic [31:0] op1;
        flags_t      flags;
    } sh_req_t;

    typedef struct packed {
        logic [31:0] op2;
        logic        shift_carry;
        logic [3:0]  opcode;
        logic        set;
        logic [3:0]  rd;
        logic [31:0] op1;
        flags_t      flags;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] result;
        logic [3:0]  rd;
        logic        write;
        logic        is_pc;
        flags_t      flags;
    } result_t;

endpackage

// ===== rtl/adpa_decode.sv =====
// Stage one: instruction decode and classification of the operand 2 shift.
module adpa_decode
    import adpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        advance,
    input  logic [31:0] instruction,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    input  logic [31:0] shift_value,
    input  flags_t      flags_in,
    output logic        out_valid,
    output sh_req_t     out_word
);

    logic    valid_reg;
    sh_req_t word_reg;
    sh_req_t word_next;
    logic [4:0] rot;
    logic [7:0] rs8;
    logic [4:0] imm_amt;
    logic [1:0] stype;

    assign rot     = {instruction[11:8], 1'b0};
    assign rs8     = shift_value[7:0];
    assign imm_amt = instruction[11:7];
    assign stype   = instruction[6:5];

    always_comb
    begin
        word_next.opcode      = instruction[24:21];
        word_next.set         = instruction[20];
        word_next.rd          = instruction[15:12];
        word_next.op1         = first_value;
        word_next.flags       = flags_in;
        word_next.value       = second_value;
        word_next.amount      = imm_amt;
        word_next.kind        = SK_PASS;
        word_next.fixed_carry = flags_in.c;
        if (instruction[25])
        begin
            word_next.value  = {24'd0, instruction[7:0]};
            word_next.amount = rot;
            word_next.kind   = (rot == 5'd0) ? SK_PASS : SK_ROR;
        end
        else if (instruction[4])
        begin
            word_next.amount = rs8[4:0];
            if (rs8 != 8'd0)
            begin
                case (stype)
                    ST_LSL:
                    begin
                        if (rs8[7:5] == 3'd0)
                        begin
                            word_next.kind = SK_LSL;
                        end
                        else
                        begin
                            word_next.kind        = SK_ZERO;
                            word_next.fixed_carry = (rs8 == 8'd32) & second_value[0];
                        end
                    end
                    ST_LSR:
                    begin
                        if (rs8[7:5] == 3'd0)
                        begin
                            word_next.kind = SK_LSR;
                        end
                        else
                        begin
                            word_next.kind        = SK_ZERO;
                            word_next.fixed_carry = (rs8 == 8'd32) & second_value[31];
                        end
                    end
                    ST_ASR:
                    begin
                        word_next.kind = (rs8[7:5] == 3'd0) ? SK_ASR : SK_SIGN;
                    end
                    default:
                    begin
                        if (rs8[4:0] == 5'd0)
                        begin
                            word_next.kind        = SK_PASS;
                            word_next.fixed_carry = second_value[31];
                        end
                        else
                        begin
                            word_next.kind = SK_ROR;
                        end
                    end
                endcase
            end
        end
        else if (imm_amt == 5'd0)
        begin
            case (stype)
                ST_LSL:
                begin
                    word_next.kind = SK_PASS;
                end
                ST_LSR:
                begin
                    word_next.kind        = SK_ZERO;
                    word_next.fixed_carry = second_value[31];
                end
                ST_ASR:
                begin
                    word_next.kind = SK_SIGN;
                end
                default:
                begin
                    word_next.kind = SK_RRX;
                end
            endcase
        end
        else
        begin
            case (stype)
                ST_LSL:  word_next.kind = SK_LSL;
                ST_LSR:  word_next.kind = SK_LSR;
                ST_ASR:  word_next.kind = SK_ASR;
                default: word_next.kind = SK_ROR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/adpa_shift.sv =====
// Stage two: barrel shifter that forms operand 2 and the shifter carry.
module adpa_shift
    import adpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     advance,
    input  sh_req_t  in_word,
    output logic     out_valid,
    output alu_req_t out_word
);

    logic     valid_reg;
    alu_req_t word_reg;
    alu_req_t word_next;
    logic [4:0]  neg_amt;
    logic [4:0]  low_idx;
    logic [31:0] v;

    assign v       = in_word.value;
    assign neg_amt = 5'd0 - in_word.amount;
    assign low_idx = in_word.amount - 5'd1;

    always_comb
    begin
        word_next.opcode = in_word.opcode;
        word_next.set    = in_word.set;
        word_next.rd     = in_word.rd;
        word_next.op1    = in_word.op1;
        word_next.flags  = in_word.flags;
        case (in_word.kind)
            SK_LSL:
            begin
                word_next.op2         = v << in_word.amount;
                word_next.shift_carry = v[neg_amt];
            end
            SK_LSR:
            begin
                word_next.op2         = v >> in_word.amount;
                word_next.shift_carry = v[low_idx];
            end
            SK_ASR:
            begin
                word_next.op2         = 32'($signed(v) >>> in_word.amount);
                word_next.shift_carry = v[low_idx];
            end
            SK_ROR:
            begin
                word_next.op2         = (v >> in_word.amount) | (v << neg_amt);
                word_next.shift_carry = v[low_idx];
            end
            SK_RRX:
            begin
                word_next.op2         = {in_word.flags.c, v[31:1]};
                word_next.shift_carry = v[0];
            end
            SK_ZERO:
            begin
                word_next.op2         = 32'd0;
                word_next.shift_carry = in_word.fixed_carry;
            end
            SK_SIGN:
            begin
                word_next.op2         = {32{v[31]}};
                word_next.shift_carry = v[31];
            end
            default:
            begin
                word_next.op2         = v;
                word_next.shift_carry = in_word.fixed_carry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/adpa_exec.sv =====
// Stage three: adder, logic operations and flag update, feeding the output register.
module adpa_exec
    import adpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     advance,
    input  alu_req_t in_word,
    output logic     out_valid,
    output result_t  out_word
);

    logic    valid_reg;
    result_t word_reg;
    result_t word_next;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] sum;
    logic [31:0] res;
    logic        logical;
    logic [31:0] op1;
    logic [31:0] op2;

    assign op1 = in_word.op1;
    assign op2 = in_word.op2;

    always_comb
    begin
        add_a   = op1;
        add_b   = op2;
        add_cin = 1'b0;
        case (in_word.opcode)
            OP_SUB, OP_CMP:
            begin
                add_b   = ~op2;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_a   = op2;
                add_b   = ~op1;
                add_cin = 1'b1;
            end
            OP_ADC:
            begin
                add_cin = in_word.flags.c;
            end
            OP_SBC:
            begin
                add_b   = ~op2;
                add_cin = in_word.flags.c;
            end
            OP_RSC:
            begin
                add_a   = op2;
                add_b   = ~op1;
                add_cin = in_word.flags.c;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

    always_comb
    begin
        logical = 1'b1;
        case (in_word.opcode)
            OP_AND, OP_TST: res = op1 & op2;
            OP_EOR, OP_TEQ: res = op1 ^ op2;
            OP_ORR:         res = op1 | op2;
            OP_MOV:         res = op2;
            OP_BIC:         res = op1 & ~op2;
            OP_MVN:         res = ~op2;
            default:
            begin
                res     = sum[31:0];
                logical = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        word_next.result = res;
        word_next.rd     = in_word.rd;
        word_next.write  = (in_word.opcode[3:2] != 2'b10);
        word_next.is_pc  = word_next.write && (in_word.rd == RD_PC);
        word_next.flags  = in_word.flags;
        if (in_word.set)
        begin
            word_next.flags.n = res[31];
            word_next.flags.z = (res == 32'd0);
            if (logical)
            begin
                word_next.flags.c = in_word.shift_carry;
            end
            else
            begin
                word_next.flags.c = sum[32];
                word_next.flags.v = (add_a[31] ^ res[31]) & (add_b[31] ^ res[31]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/arm_data_processing_alu_core.sv =====
// Top level of the ARM data-processing ALU with barrel shifter.
// The block takes one data-processing word per cycle while the output is not
// stalled; each word passes through decode, shift and ALU. The three register
// stages are decode, barrel shift and ALU, and the last one is the output
// register. Each stage moves on whenever it is empty or the stage after it
// moves, so bubbles close up and the input is stalled only when all three
// stages hold words and the output is stalled. Flags change only when the S
// bit is set, and TST, TEQ, CMP and CMN report their value without writing it.
module arm_data_processing_alu_core
    import adpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    input  logic [31:0] shift_value,
    input  logic        flag_n_in,
    input  logic        flag_z_in,
    input  logic        flag_c_in,
    input  logic        flag_v_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result,
    output logic [3:0]  dest_reg,
    output logic        write_result,
    output logic        dest_is_pc,
    output logic        flag_n_out,
    output logic        flag_z_out,
    output logic        flag_c_out,
    output logic        flag_v_out
);

    flags_t   flags_in;
    sh_req_t  s1_word;
    alu_req_t s2_word;
    result_t  s3_word;
    logic     s1_valid;
    logic     s2_valid;
    logic     s3_valid;
    logic     en1;
    logic     en2;
    logic     en3;

    assign flags_in = '{n: flag_n_in, z: flag_z_in, c: flag_c_in, v: flag_v_in};

    assign en3      = !s3_valid || !out_stall;
    assign en2      = !s2_valid || en3;
    assign en1      = !s1_valid || en2;
    assign in_stall = !en1;

    adpa_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .advance      (en1),
        .instruction  (instruction),
        .first_value  (first_value),
        .second_value (second_value),
        .shift_value  (shift_value),
        .flags_in     (flags_in),
        .out_valid    (s1_valid),
        .out_word     (s1_word)
    );

    adpa_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .advance   (en2),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_word  (s2_word)
    );

    adpa_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .advance   (en3),
        .in_word   (s2_word),
        .out_valid (s3_valid),
        .out_word  (s3_word)
    );

    assign out_valid    = s3_valid;
    assign result       = s3_word.result;
    assign dest_reg     = s3_word.rd;
    assign write_result = s3_word.write;
    assign dest_is_pc   = s3_word.is_pc;
    assign flag_n_out   = s3_word.flags.n;
    assign flag_z_out   = s3_word.flags.z;
    assign flag_c_out   = s3_word.flags.c;
    assign flag_v_out   = s3_word.flags.v;

    // The input is held back only when every stage is full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
        else $error("input stalled while the pipeline has room");

    // A word in stage one that moves on must show up in stage two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && en2) |=> s2_valid)
        else $error("word lost between decode and shift stages");

    // A word in stage two that moves on must show up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && en3) |=> out_valid)
        else $error("word lost between shift and ALU stages");

    // A refetch is flagged only for a written result to the program counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dest_is_pc) |-> (write_result && (dest_reg == RD_PC)))
        else $error("refetch flagged without a write to the program counter");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ARM data-processing ALU core with its barrel shifter.
module tb
    import adpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1750;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [31:0] shift_value;
        flags_t      flags;
    } dp_word_t;

    typedef struct {
        dp_word_t word;
        bit       known;
        result_t  want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] instruction = '0;
    logic [31:0] first_value = '0;
    logic [31:0] second_value = '0;
    logic [31:0] shift_value = '0;
    logic        flag_n_in = 1'b0;
    logic        flag_z_in = 1'b0;
    logic        flag_c_in = 1'b0;
    logic        flag_v_in = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result;
    logic [3:0]  dest_reg;
    logic        write_result;
    logic        dest_is_pc;
    logic        flag_n_out;
    logic        flag_z_out;
    logic        flag_c_out;
    logic        flag_v_out;

    result_t   pending_results[$];
    stim_row_t directed[$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;
    bit        hold_due = 1'b0;
    bit        hold_done = 1'b0;

    arm_data_processing_alu_core dut (.*);

    always #5 clk = ~clk;

    function automatic logic [31:0] enc(input logic imm, input logic [3:0] opc, input logic s,
                                        input logic [3:0] rd, input logic [11:0] operand);
        return {4'he, 2'b00, imm, opc, s, 4'h0, rd, operand};
    endfunction

    // Returns the shifter carry above the shifted value.
    function automatic logic [32:0] shift_operand(input logic [31:0] v, input logic [1:0] kind,
                                                  input logic [7:0] amount, input logic by_reg,
                                                  input logic cin);
        int   a;
        int   r;
        logic s;
        a = int'(amount);
        s = v[31];
        if (a == 0)
        begin
            if (by_reg || kind == ST_LSL)
                return {cin, v};
            case (kind)
                ST_LSR:  return {s, 32'h0};
                ST_ASR:  return {s, {32{s}}};
                default: return {v[0], cin, v[31:1]};
            endcase
        end
        case (kind)
            ST_LSL:
            begin
                if (a < 32)
                    return {v[32 - a], v << a};
                return {(a == 32) & v[0], 32'h0};
            end
            ST_LSR:
            begin
                if (a < 32)
                    return {v[a - 1], v >> a};
                return {(a == 32) & s, 32'h0};
            end
            ST_ASR:
            begin
                if (a < 32)
                    return {v[a - 1], $signed(v) >>> a};
                return {s, {32{s}}};
            end
            default:
            begin
                r = a % 32;
                if (r == 0)
                    return {s, v};
                return {v[r - 1], (v >> r) | (v << (32 - r))};
            end
        endcase
    endfunction

    // Returns overflow, carry and sum from the most significant bit down.
    function automatic logic [33:0] add_with_flags(input logic [31:0] a, input logic [31:0] b,
                                                   input logic cin);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {32'h0, cin};
        return {(a[31] ^ sum[31]) & (b[31] ^ sum[31]), sum};
    endfunction

    function automatic result_t execute_word(input dp_word_t w);
        logic [3:0]  opc;
        logic [4:0]  rot;
        logic [31:0] imm;
        logic [31:0] op1;
        logic [31:0] op2;
        logic        sc;
        logic [33:0] arith;
        logic        logical;
        result_t     e;
        opc = w.instruction[24:21];
        op1 = w.first_value;
        if (w.instruction[25])
        begin
            rot = {w.instruction[11:8], 1'b0};
            imm = {24'h0, w.instruction[7:0]};
            op2 = (rot == 0) ? imm : ((imm >> rot) | (imm << (32 - rot)));
            sc = (rot == 0) ? w.flags.c : op2[31];
        end
        else if (w.instruction[4])
            {sc, op2} = shift_operand(w.second_value, w.instruction[6:5], w.shift_value[7:0],
                                      1'b1, w.flags.c);
        else
            {sc, op2} = shift_operand(w.second_value, w.instruction[6:5],
                                      {3'b000, w.instruction[11:7]}, 1'b0, w.flags.c);
        logical = 1'b0;
        arith = '0;
        e.result = '0;
        case (opc)
            OP_AND, OP_TST:
            begin
                e.result = op1 & op2;
                logical = 1'b1;
            end
            OP_EOR, OP_TEQ:
            begin
                e.result = op1 ^ op2;
                logical = 1'b1;
            end
            OP_SUB, OP_CMP: arith = add_with_flags(op1, ~op2, 1'b1);
            OP_RSB:         arith = add_with_flags(op2, ~op1, 1'b1);
            OP_ADD, OP_CMN: arith = add_with_flags(op1, op2, 1'b0);
            OP_ADC:         arith = add_with_flags(op1, op2, w.flags.c);
            OP_SBC:         arith = add_with_flags(op1, ~op2, w.flags.c);
            OP_RSC:         arith = add_with_flags(op2, ~op1, w.flags.c);
            OP_ORR:
            begin
                e.result = op1 | op2;
                logical = 1'b1;
            end
            OP_MOV:
            begin
                e.result = op2;
                logical = 1'b1;
            end
            OP_BIC:
            begin
                e.result = op1 & ~op2;
                logical = 1'b1;
            end
            default:
            begin
                e.result = ~op2;
                logical = 1'b1;
            end
        endcase
        if (!logical)
            e.result = arith[31:0];
        e.rd = w.instruction[15:12];
        e.write = (opc >= OP_TST && opc <= OP_CMN) ? 1'b0 : 1'b1;
        e.is_pc = e.write && e.rd == RD_PC;
        e.flags = w.flags;
        if (w.instruction[20])
        begin
            e.flags.n = e.result[31];
            e.flags.z = (e.result == 32'h0);
            if (logical)
                e.flags.c = sc;
            else
            begin
                e.flags.c = arith[32];
                e.flags.v = arith[33];
            end
        end
        return e;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic offer_word(input dp_word_t w, input result_t want);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instruction <= w.instruction;
        first_value <= w.first_value;
        second_value <= w.second_value;
        shift_value <= w.shift_value;
        flag_n_in <= w.flags.n;
        flag_z_in <= w.flags.z;
        flag_c_in <= w.flags.c;
        flag_v_in <= w.flags.v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(want);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h, got %h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, result %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result", want.result, result);
                check_field("dest_reg", 32'(want.rd), 32'(dest_reg));
                check_field("write_result", 32'(want.write), 32'(write_result));
                check_field("dest_is_pc", 32'(want.is_pc), 32'(dest_is_pc));
                check_field("flag_n_out", 32'(want.flags.n), 32'(flag_n_out));
                check_field("flag_z_out", 32'(want.flags.z), 32'(flag_z_out));
                check_field("flag_c_out", 32'(want.flags.c), 32'(flag_c_out));
                check_field("flag_v_out", 32'(want.flags.v), 32'(flag_v_out));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("arm_data_processing_alu_core test failed");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_due && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
            end
            else
                out_stall <= !calm && $urandom_range(99) < 22;
        end
    end

    initial
    begin
        dp_word_t    w;
        logic [11:0] operand;
        logic [31:0] rs_val;
        logic [31:0] ins;

        directed.push_back('{'{enc(1'b1, OP_MOV, 1'b1, 4'd1, 12'h000), 32'h1234_5678,
            32'h0, 32'h0, flags_t'(4'b1011)}, 1'b1,
            '{32'h0000_0000, 4'd1, 1'b1, 1'b0, flags_t'(4'b0111)}});
        directed.push_back('{'{enc(1'b1, OP_MOV, 1'b1, 4'd2, 12'h4ff), 32'h0,
            32'h0, 32'h0, flags_t'(4'b0000)}, 1'b1,
            '{32'hff00_0000, 4'd2, 1'b1, 1'b0, flags_t'(4'b1010)}});
        directed.push_back('{'{enc(1'b1, OP_MVN, 1'b1, 4'd3, 12'h000), 32'h0,
            32'h0, 32'h0, flags_t'(4'b0001)}, 1'b1,
            '{32'hffff_ffff, 4'd3, 1'b1, 1'b0, flags_t'(4'b1001)}});
        directed.push_back('{'{enc(1'b1, OP_ADD, 1'b1, 4'd4, 12'h001), 32'hffff_ffff,
            32'h0, 32'h0, flags_t'(4'b0000)}, 1'b1,
            '{32'h0000_0000, 4'd4, 1'b1, 1'b0, flags_t'(4'b0110)}});
        directed.push_back('{'{enc(1'b1, OP_ADD, 1'b1, 4'd5, 12'h001), 32'h7fff_ffff,
            32'h0, 32'h0, flags_t'(4'b0000)}, 1'b1,
            '{32'h8000_0000, 4'd5, 1'b1, 1'b0, flags_t'(4'b1001)}});
        directed.push_back('{'{enc(1'b1, OP_SUB, 1'b1, 4'd6, 12'h001), 32'h0,
            32'h0, 32'h0, flags_t'(4'b0110)}, 1'b1,
            '{32'hffff_ffff, 4'd6, 1'b1, 1'b0, flags_t'(4'b1000)}});
        directed.push_back('{'{enc(1'b1, OP_MOV, 1'b1, RD_PC, 12'h004), 32'h0,
            32'h0, 32'h0, flags_t'(4'b0000)}, 1'b1,
            '{32'h0000_0004, RD_PC, 1'b1, 1'b1, flags_t'(4'b0000)}});
        directed.push_back('{'{enc(1'b1, OP_TST, 1'b1, RD_PC, 12'h001), 32'h1,
            32'h0, 32'h0, flags_t'(4'b0101)}, 1'b1,
            '{32'h0000_0001, RD_PC, 1'b0, 1'b0, flags_t'(4'b0001)}});

        // One row per operation, each carrying one of the shifter corner cases.
        for (int k = 0; k < 16; k++)
        begin
            rs_val = $urandom() & 32'hffff_ff00;
            case (k)
                0:  operand = {5'd0, ST_LSL, 1'b0, 4'd2};
                1:  operand = {5'd0, ST_LSR, 1'b0, 4'd2};
                2:  operand = {5'd0, ST_ASR, 1'b0, 4'd2};
                3:  operand = {5'd0, ST_ROR, 1'b0, 4'd2};
                4:  operand = {4'd3, 1'b0, ST_LSL, 1'b1, 4'd2};
                5:
                begin
                    operand = {4'd3, 1'b0, ST_LSL, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd32;
                end
                6:
                begin
                    operand = {4'd3, 1'b0, ST_LSR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd32;
                end
                7:
                begin
                    operand = {4'd3, 1'b0, ST_LSR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd33;
                end
                8:
                begin
                    operand = {4'd3, 1'b0, ST_ASR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd40;
                end
                9:
                begin
                    operand = {4'd3, 1'b0, ST_ROR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd64;
                end
                10:
                begin
                    operand = {4'd3, 1'b1, ST_ROR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd32;
                end
                11:
                begin
                    operand = {4'd3, 1'b0, ST_ASR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd255;
                end
                12: operand = {5'd31, ST_LSL, 1'b0, 4'd2};
                13: operand = 12'h102;
                14:
                begin
                    operand = {4'd3, 1'b0, ST_ROR, 1'b1, 4'd2};
                    rs_val[7:0] = 8'd31;
                end
                default: operand = {5'd31, ST_ASR, 1'b0, 4'd2};
            endcase
            w.instruction = enc(k == 13, 4'(k), k != 10, 4'(k), operand);
            w.first_value = $urandom();
            w.second_value = 32'h8000_0001;
            w.shift_value = rs_val;
            w.flags = flags_t'(4'(k * 5));
            directed.push_back('{w, 1'b0, '0});
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer_word(directed[i].word,
                       directed[i].known ? directed[i].want : execute_word(directed[i].word));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 500 && i < 900);
            if (i == 1100)
                hold_due = 1'b1;
            if (i == 1400)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            ins = $urandom();
            rs_val = $urandom();
            case ($urandom_range(9))
                0, 1, 2: ins[25] = 1'b1;
                3, 4, 5:
                begin
                    ins[25] = 1'b0;
                    ins[4] = 1'b0;
                    if ($urandom_range(2) == 0)
                        ins[11:7] = 5'd0;
                end
                default:
                begin
                    ins[25] = 1'b0;
                    ins[4] = 1'b1;
                    case ($urandom_range(5))
                        0:       rs_val[7:0] = 8'd0;
                        1:       rs_val[7:0] = 8'd32;
                        2:       rs_val[7:0] = 8'($urandom_range(7) * 32);
                        3:       rs_val[7:0] = 8'($urandom_range(255, 33));
                        default: rs_val[7:0] = 8'($urandom_range(31, 1));
                    endcase
                end
            endcase
            w.instruction = ins;
            w.first_value = pick_value();
            w.second_value = pick_value();
            w.shift_value = rs_val;
            w.flags = flags_t'(4'($urandom()));
            offer_word(w, execute_word(w));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("arm_data_processing_alu_core test passed");
        else
            $display("arm_data_processing_alu_core test failed");
        $finish;
    end

endmodule
